@@ hw/rtl/trcr_pkg.sv @@
package trcr_pkg;

    // divider and accumulator width
    localparam int DW = 64;
    // shared multiplier operand and product widths
    localparam int MW = 20;
    localparam int PW = 2 * MW;

    typedef enum logic [1:0] {
        EDGE_01,
        EDGE_02,
        EDGE_12
    } edge_t;

endpackage

@@ hw/rtl/triangle_column_rasterizer_top.sv @@
// a third vertex load starts the setup (rotate, inverse, determinant) plus a column search
// a pixel inside a column runs two 64-step divisions, one per attribute (one if ATTR_COUNT is 1)
// each column visited on a change adds two 64-step edge divisions
// one item at a time; s_tready is high only when the sequencer is idle
// rst_n asynchronous: no triangle active, output empty; vertex store undefined until loaded
module triangle_column_rasterizer_top
    import trcr_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 4,
    parameter int ATTR_COUNT      = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // vertex_index, vertex_x, vertex_y, vertex_attr_first,
                                  // vertex_attr_second, zero pad
    input  logic [0:0]  s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // pixel_x, pixel_y, attr_first, attr_second
    output logic [0:0]  m_tuser,  // pixel_valid
    output logic        m_tlast   // last_pixel
);

    localparam int XW  = 18;
    localparam int XSW = XW + COORD_FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_ROT, S_INV, S_DET0, S_DET1, S_DET2, S_CHK,
        S_E0, S_E1, S_E2, S_EDIV, S_EWAIT,
        S_IP0, S_IP1, S_IP2, S_IP3, S_IP4,
        S_K0, S_K1, S_K2, S_K3, S_K4, S_KDIV, S_KWAIT,
        S_ADV, S_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic signed [15:0] vx_reg [3], vx_next [3];
    logic signed [15:0] vy_reg [3], vy_next [3];
    logic signed [15:0] va_reg [3], va_next [3];
    logic signed [15:0] vb_reg [3], vb_next [3];
    logic signed [16:0] inv_reg [4], inv_next [4];
    logic signed [35:0] det_reg, det_next;
    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next, top_reg, top_next, lo_reg, lo_next;
    logic walking_reg, walking_next;
    edge_t lo_edge_reg, lo_edge_next, hi_edge_reg, hi_edge_next;
    logic edge_hi_reg, edge_hi_next;
    logic signed [DW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [35:0] p_reg, p_next, q_reg, q_next;
    logic k_reg, k_next;
    logic emit_reg, emit_next;
    logic res_valid_reg, res_valid_next;
    logic [11:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic signed [15:0] res_a_reg [2], res_a_next [2];
    logic m_tvalid_reg, m_tvalid_next;
    logic [55:0] m_tdata_reg, m_tdata_next;
    logic m_tuser_reg, m_tuser_next;
    logic m_tlast_reg, m_tlast_next;

    // shared multiplier
    logic signed [MW-1:0] mul_a, mul_b;

    // divider
    logic                 div_start;
    logic signed [DW-1:0] div_num;
    logic        [DW-1:0] div_den;
    logic                 div_done;
    logic signed [DW-1:0] div_q;

    trcr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q)
    );

    // input fields
    logic [1:0]         in_idx;
    logic signed [15:0] in_x, in_y, in_a, in_b;
    assign in_idx = s_tdata[1:0];
    assign in_x   = s_tdata[17:2];
    assign in_y   = s_tdata[33:18];
    assign in_a   = s_tdata[49:34];
    assign in_b   = s_tdata[65:50];

    // current edge endpoints
    edge_t              cur_edge;
    logic signed [15:0] epx, epy, erx, ery;
    logic signed [16:0] e_dx, e_dy, e_adx;
    assign cur_edge = edge_hi_reg ? hi_edge_reg : lo_edge_reg;

    always_comb
    begin
        unique case (cur_edge)
            EDGE_01:
            begin
                epx = vx_reg[0]; epy = vy_reg[0]; erx = vx_reg[1]; ery = vy_reg[1];
            end
            EDGE_02:
            begin
                epx = vx_reg[0]; epy = vy_reg[0]; erx = vx_reg[2]; ery = vy_reg[2];
            end
            default:
            begin
                epx = vx_reg[1]; epy = vy_reg[1]; erx = vx_reg[2]; ery = vy_reg[2];
            end
        endcase
    end

    assign e_dx  = 17'(erx) - 17'(epx);
    assign e_dy  = 17'(ery) - 17'(epy);
    assign e_adx = e_dx[16] ? -e_dx : e_dx;

    // pixel positions in coordinate units
    logic signed [XSW-1:0] xs_wide, ys_wide;
    logic signed [MW-1:0]  xs, ys, dxp, dyp, e_off;
    assign xs_wide = XSW'(x_reg) <<< COORD_FRAC_BITS;
    assign ys_wide = XSW'(y_reg) <<< COORD_FRAC_BITS;
    assign xs      = MW'(xs_wide);
    assign ys      = MW'(ys_wide);
    assign dxp     = xs - MW'(vx_reg[0]);
    assign dyp     = ys - MW'(vy_reg[0]);
    assign e_off   = xs - MW'(epx);

    // column span limits
    logic                 second_far;
    logic signed [XW-1:0] last_x, split_x, start_x;
    assign second_far = vx_reg[1] >= vx_reg[2];
    assign last_x  = XW'(second_far ? vx_reg[1] : vx_reg[2]) >>> COORD_FRAC_BITS;
    assign split_x = XW'(second_far ? vx_reg[2] : vx_reg[1]) >>> COORD_FRAC_BITS;
    assign start_x = (XW'(vx_reg[0]) + XW'((1 << COORD_FRAC_BITS) - 1)) >>> COORD_FRAC_BITS;

    // attribute differences for the current attribute
    logic signed [15:0] al, be, ga;
    logic signed [16:0] db, dc;
    assign al = k_reg ? vb_reg[0] : va_reg[0];
    assign be = k_reg ? vb_reg[1] : va_reg[1];
    assign ga = k_reg ? vb_reg[2] : va_reg[2];
    assign db = 17'(be) - 17'(al);
    assign dc = 17'(ga) - 17'(al);

    // lowest-x vertex
    logic [1:0] mi;
    always_comb
    begin
        mi = 2'd0;
        if (vx_reg[1] < vx_reg[0])
            mi = 2'd1;
        if (vx_reg[2] < ((mi == 2'd1) ? vx_reg[1] : vx_reg[0]))
            mi = 2'd2;
    end

    logic signed [DW-1:0] det_w, det_abs, acc_adj, edge_num, attr_v;
    logic signed [XW-1:0] hi_val;
    assign det_w   = DW'(det_reg);
    assign det_abs = det_reg[35] ? -det_w : det_w;
    assign acc_adj = det_reg[35] ? -acc_reg : acc_reg;
    assign edge_num = (e_dx == '0) ? DW'(epy) : (e_dx[16] ? -acc_reg : acc_reg);
    assign attr_v  = DW'(al) + div_q;
    assign hi_val  = XW'(div_q);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_DET0: begin mul_a = MW'(inv_reg[0]); mul_b = MW'(inv_reg[3]); end
            S_DET1: begin mul_a = MW'(inv_reg[1]); mul_b = MW'(inv_reg[2]); end
            S_E0:   begin mul_a = MW'(epy);        mul_b = MW'(e_dx);       end
            S_E1:   begin mul_a = MW'(e_dy);       mul_b = e_off;           end
            S_IP0:  begin mul_a = MW'(inv_reg[0]); mul_b = dxp;             end
            S_IP1:  begin mul_a = MW'(inv_reg[1]); mul_b = dyp;             end
            S_IP2:  begin mul_a = MW'(inv_reg[2]); mul_b = dxp;             end
            S_IP3:  begin mul_a = MW'(inv_reg[3]); mul_b = dyp;             end
            S_K0:   begin mul_a = signed'(MW'(p_reg[17:0])); mul_b = MW'(db); end
            S_K1:   begin mul_a = MW'(signed'(p_reg[35:18])); mul_b = MW'(db); end
            S_K2:   begin mul_a = signed'(MW'(q_reg[17:0])); mul_b = MW'(dc); end
            S_K3:   begin mul_a = MW'(signed'(q_reg[35:18])); mul_b = MW'(dc); end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        inv_next       = inv_reg;
        det_next       = det_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        top_next       = top_reg;
        lo_next        = lo_reg;
        walking_next   = walking_reg;
        lo_edge_next   = lo_edge_reg;
        hi_edge_next   = hi_edge_reg;
        edge_hi_next   = edge_hi_reg;
        acc_next       = acc_reg;
        prod_next      = mul_a * mul_b;
        p_next         = p_reg;
        q_next         = q_reg;
        k_next         = k_reg;
        emit_next      = emit_reg;
        res_valid_next = res_valid_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_a_next     = res_a_reg;
        m_tvalid_next  = m_tvalid_reg & ~m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tlast_next   = m_tlast_reg;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0] == 1'b0)
                    begin
                        emit_next = 1'b0;
                        if (in_idx != 2'd3)
                        begin
                            vx_next[in_idx] = in_x;
                            vy_next[in_idx] = in_y;
                            va_next[in_idx] = in_a;
                            vb_next[in_idx] = in_b;
                            walking_next    = 1'b0;
                            if (in_idx == 2'd2)
                                state_next = S_ROT;
                        end
                    end
                    else
                    begin
                        emit_next      = 1'b1;
                        res_valid_next = walking_reg;
                        res_x_next     = x_reg[11:0];
                        res_y_next     = y_reg[11:0];
                        state_next     = walking_reg ? S_IP0 : S_EMIT;
                    end
                end
            end
            S_ROT:
            begin
                if (mi == 2'd1)
                begin
                    vx_next = '{vx_reg[1], vx_reg[2], vx_reg[0]};
                    vy_next = '{vy_reg[1], vy_reg[2], vy_reg[0]};
                    va_next = '{va_reg[1], va_reg[2], va_reg[0]};
                    vb_next = '{vb_reg[1], vb_reg[2], vb_reg[0]};
                end
                else if (mi == 2'd2)
                begin
                    vx_next = '{vx_reg[2], vx_reg[0], vx_reg[1]};
                    vy_next = '{vy_reg[2], vy_reg[0], vy_reg[1]};
                    va_next = '{va_reg[2], va_reg[0], va_reg[1]};
                    vb_next = '{vb_reg[2], vb_reg[0], vb_reg[1]};
                end
                state_next = S_INV;
            end
            S_INV:
            begin
                inv_next[0] = 17'(vy_reg[2]) - 17'(vy_reg[0]);
                inv_next[1] = 17'(vx_reg[0]) - 17'(vx_reg[2]);
                inv_next[2] = 17'(vy_reg[0]) - 17'(vy_reg[1]);
                inv_next[3] = 17'(vx_reg[1]) - 17'(vx_reg[0]);
                state_next  = S_DET0;
            end
            S_DET0:
                state_next = S_DET1;
            S_DET1:
            begin
                acc_next   = DW'(prod_reg);
                state_next = S_DET2;
            end
            S_DET2:
            begin
                det_next = 36'(acc_reg - DW'(prod_reg));
                if (acc_reg == DW'(prod_reg))
                    state_next = S_IDLE;
                else
                begin
                    x_next     = start_x;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (x_reg > last_x)
                begin
                    walking_next = 1'b0;
                    state_next   = emit_reg ? S_EMIT : S_IDLE;
                end
                else
                begin
                    if (x_reg <= split_x)
                    begin
                        lo_edge_next = EDGE_01;
                        hi_edge_next = EDGE_02;
                    end
                    else if (second_far)
                    begin
                        lo_edge_next = EDGE_01;
                        hi_edge_next = EDGE_12;
                    end
                    else
                    begin
                        lo_edge_next = EDGE_12;
                        hi_edge_next = EDGE_02;
                    end
                    edge_hi_next = 1'b0;
                    state_next   = S_E0;
                end
            end
            S_E0:
                state_next = S_E1;
            S_E1:
            begin
                acc_next   = DW'(prod_reg);
                state_next = S_E2;
            end
            S_E2:
            begin
                acc_next   = acc_reg + DW'(prod_reg);
                state_next = S_EDIV;
            end
            S_EDIV:
            begin
                div_start = 1'b1;
                // lower edge rounds up: ceil(n/d) = -floor(-n/d)
                div_num   = edge_hi_reg ? edge_num : -edge_num;
                div_den   = (e_dx == '0) ? DW'(1 << COORD_FRAC_BITS)
                                         : (DW'(e_adx) << COORD_FRAC_BITS);
                state_next = S_EWAIT;
            end
            S_EWAIT:
            begin
                if (div_done)
                begin
                    if (!edge_hi_reg)
                    begin
                        lo_next      = XW'(-div_q);
                        edge_hi_next = 1'b1;
                        state_next   = S_E0;
                    end
                    else if (lo_reg <= hi_val)
                    begin
                        y_next       = lo_reg;
                        top_next     = hi_val;
                        walking_next = 1'b1;
                        state_next   = emit_reg ? S_EMIT : S_IDLE;
                    end
                    else
                    begin
                        x_next     = x_reg + XW'(1);
                        state_next = S_CHK;
                    end
                end
            end
            S_IP0:
                state_next = S_IP1;
            S_IP1:
            begin
                acc_next   = DW'(prod_reg);
                state_next = S_IP2;
            end
            S_IP2:
            begin
                p_next     = 36'(acc_reg + DW'(prod_reg));
                state_next = S_IP3;
            end
            S_IP3:
            begin
                acc_next   = DW'(prod_reg);
                state_next = S_IP4;
            end
            S_IP4:
            begin
                q_next     = 36'(acc_reg + DW'(prod_reg));
                k_next     = 1'b0;
                state_next = S_K0;
            end
            S_K0:
                state_next = S_K1;
            S_K1:
            begin
                acc_next   = DW'(prod_reg);
                state_next = S_K2;
            end
            S_K2:
            begin
                acc_next   = acc_reg + (DW'(prod_reg) <<< 18);
                state_next = S_K3;
            end
            S_K3:
            begin
                acc_next   = acc_reg + DW'(prod_reg);
                state_next = S_K4;
            end
            S_K4:
            begin
                acc_next   = acc_reg + (DW'(prod_reg) <<< 18);
                state_next = S_KDIV;
            end
            S_KDIV:
            begin
                // round to nearest, ties up
                div_start  = 1'b1;
                div_num    = (acc_adj <<< 1) + det_abs;
                div_den    = det_abs << 1;
                state_next = S_KWAIT;
            end
            S_KWAIT:
            begin
                if (div_done)
                begin
                    if (attr_v > DW'(32767))
                        res_a_next[k_reg] = 16'sh7fff;
                    else if (attr_v < -DW'(32768))
                        res_a_next[k_reg] = -16'sh8000;
                    else
                        res_a_next[k_reg] = 16'(attr_v);
                    if (!k_reg && ATTR_COUNT > 1)
                    begin
                        k_next     = 1'b1;
                        state_next = S_K0;
                    end
                    else
                        state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                if (y_reg < top_reg)
                begin
                    y_next     = y_reg + XW'(1);
                    state_next = S_EMIT;
                end
                else
                begin
                    x_next     = x_reg + XW'(1);
                    state_next = S_CHK;
                end
            end
            S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_valid_reg;
                    m_tlast_next  = res_valid_reg & ~walking_reg;
                    if (res_valid_reg)
                        m_tdata_next = {(ATTR_COUNT > 1) ? res_a_reg[1] : 16'sd0,
                                        res_a_reg[0], res_y_reg, res_x_reg};
                    else
                        m_tdata_next = '0;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            walking_reg  <= 1'b0;
            x_reg        <= '0;
            y_reg        <= '0;
            top_reg      <= '0;
            emit_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            walking_reg  <= walking_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            top_reg      <= top_next;
            emit_reg     <= emit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg        <= vx_next;
        vy_reg        <= vy_next;
        va_reg        <= va_next;
        vb_reg        <= vb_next;
        inv_reg       <= inv_next;
        det_reg       <= det_next;
        lo_reg        <= lo_next;
        lo_edge_reg   <= lo_edge_next;
        hi_edge_reg   <= hi_edge_next;
        edge_hi_reg   <= edge_hi_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        p_reg         <= p_next;
        q_reg         <= q_next;
        k_reg         <= k_next;
        res_valid_reg <= res_valid_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        res_a_reg     <= res_a_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
        m_tlast_reg   <= m_tlast_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ hw/rtl/trcr_div.sv @@
module trcr_div
    import trcr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] num,
    input  logic        [DW-1:0] den,
    output logic                 done,
    output logic signed [DW-1:0] quo
);

    localparam int CW = $clog2(DW + 1);

    logic          run_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg;
    logic [DW-1:0] mag_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   rem_reg;
    logic [DW:0]   rem_sh;

    assign rem_sh = {rem_reg[DW-1:0], mag_reg[DW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(DW);
            neg_reg  <= num[DW-1];
            mag_reg  <= num[DW-1] ? DW'(-num) : DW'(num);
            den_reg  <= den;
            rem_reg  <= '0;
        end
        else if (run_reg)
        begin
            // one restoring step per cycle
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_reg <= rem_sh - {1'b0, den_reg};
                mag_reg <= {mag_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                mag_reg <= {mag_reg[DW-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // floor toward minus infinity
    assign quo  = neg_reg ? (-$signed(mag_reg) - $signed(DW'(rem_reg != '0)))
                          : $signed(mag_reg);
    assign done = done_reg;

endmodule
